// ===== hdl/rpm_pkg.sv =====
// Shared types and constants for the point-mass rocket integrator.
// No dependencies; every other file in hdl/ refers to this package.
`timescale 1ns / 1ps

package rpm_pkg;

	// Iteration counts of the bit-serial arithmetic units.
	localparam int MUL_CYCLES  = 64;
	localparam int DIV_CYCLES  = 80;
	localparam int SQRT_CYCLES = 32;

	// Magnitude cap on intermediate values: 2^62.
	localparam logic [62:0] LIM62 = 63'h4000_0000_0000_0000;

	// Magnitude of gravity (-642689 in Q16.16 m/s^2).
	localparam logic [63:0] GRAVITY_MAG = 64'd642689;

	// Right shift applied to a finished product.
	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_24
	} shift_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_DRY_MASS    = 3'd0;
	localparam logic [2:0] REG_INIT_FUEL   = 3'd1;
	localparam logic [2:0] REG_FLOW        = 3'd2;
	localparam logic [2:0] REG_EXHAUST_VEL = 3'd3;
	localparam logic [2:0] REG_DRAG        = 3'd4;
	localparam logic [2:0] REG_COS_PITCH   = 3'd5;
	localparam logic [2:0] REG_SIN_PITCH   = 3'd6;
	localparam logic [2:0] REG_TIME_STEP   = 3'd7;

endpackage

// ===== hdl/rpm_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rpm_pkg for the cycle count, the shift select and the cap.
`timescale 1ns / 1ps

module rpm_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     a,
	input  logic [63:0]     b,
	input  rpm_pkg::shift_t sh,
	output logic            done,
	output logic [62:0]     res,
	output logic            sat
);

	logic [63:0]     a_q;
	logic [127:0]    p_q;
	logic [6:0]      cnt_q;
	logic            done_q;
	rpm_pkg::shift_t sh_q;
	logic [64:0]     sum;
	logic [127:0]    w;

	// Upper half plus the multiplicand when the current multiplier bit is set.
	always_comb begin
		sum = {1'b0, p_q[127:64]} + (p_q[0] ? {1'b0, a_q} : 65'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			p_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			sh_q   <= rpm_pkg::SH_0;
		end else if (start) begin
			a_q    <= a;
			p_q    <= {64'd0, b};
			cnt_q  <= 7'(rpm_pkg::MUL_CYCLES);
			sh_q   <= sh;
			done_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			p_q    <= {sum, p_q[63:1]};
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Scale the finished product and cap it at 2^62.
	always_comb begin
		unique case (sh_q)
			rpm_pkg::SH_0:  w = p_q;
			rpm_pkg::SH_16: w = p_q >> 16;
			rpm_pkg::SH_24: w = p_q >> 24;
			default:        w = p_q;
		endcase
		sat = (|w[127:63]) | (w[62] & (|w[61:0]));
		res = sat ? rpm_pkg::LIM62 : w[62:0];
	end

	assign done = done_q;

endmodule

// ===== hdl/rpm_div.sv =====
// Restoring divider computing (n << 16) / d, one quotient bit per cycle.
// Depends on rpm_pkg for the cycle count and the quotient cap.
`timescale 1ns / 1ps

module rpm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	input  logic [40:0] d,
	output logic        done,
	output logic [62:0] q,
	output logic        sat
);

	logic [79:0] n_q;
	logic [40:0] d_q;
	logic [40:0] rem_q;
	logic [62:0] q_q;
	logic        cap_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [41:0] trial;
	logic [41:0] diff;
	logic        qb;
	logic [63:0] newq;
	logic        over;

	// One restoring step and the check against the quotient cap.
	always_comb begin
		trial = {rem_q, n_q[79]};
		diff  = trial - {1'b0, d_q};
		qb    = (trial >= {1'b0, d_q});
		newq  = {q_q, qb};
		over  = (newq > {1'b0, rpm_pkg::LIM62});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			q_q    <= '0;
			cap_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			n_q    <= {n, 16'd0};
			d_q    <= d;
			rem_q  <= '0;
			q_q    <= '0;
			cap_q  <= 1'b0;
			cnt_q  <= 7'(rpm_pkg::DIV_CYCLES);
			done_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			n_q    <= {n_q[78:0], 1'b0};
			rem_q  <= qb ? diff[40:0] : trial[40:0];
			if (!cap_q) begin
				if (over) begin
					q_q   <= rpm_pkg::LIM62;
					cap_q <= 1'b1;
				end else begin
					q_q <= newq[62:0];
				end
			end
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign q    = q_q;
	assign sat  = cap_q;

endmodule

// ===== hdl/rpm_sqrt.sv =====
// Integer square root by the digit-by-digit method, one result bit per cycle.
// Depends on rpm_pkg for the cycle count.
`timescale 1ns / 1ps

module rpm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] r
);

	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] trial;
	logic        take;

	always_comb begin
		trial = res_q + bit_q;
		take  = (x_q >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			x_q    <= x;
			res_q  <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			cnt_q  <= 6'(rpm_pkg::SQRT_CYCLES);
			done_q <= 1'b0;
		end else if (cnt_q != 6'd0) begin
			if (take) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q  <= bit_q >> 2;
			cnt_q  <= cnt_q - 6'd1;
			done_q <= (cnt_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign r    = res_q[31:0];

endmodule

// ===== hdl/rocket_point_mass_euler_step.sv =====
// Top level of the 2-D point-mass rocket integrator with drag and thrust.
// Depends on rpm_pkg, rpm_mul, rpm_div and rpm_sqrt.
//
//   Channel  Handshake              Payload
//   cfg      cfg_write              cfg_index, cfg_data
//   in       in_valid / in_stall    restart
//   out      out_valid / out_stall  positions, velocities, speed, fuel, flags
//
// A tick with fuel left runs fourteen multiplies on one shift-and-add multiplier,
// two divisions and a square root, each started in turn and awaited. A coasting
// tick skips four multiplies. A restart or a zero-mass tick goes from idle
// straight to the output state. Reset clears the state and loads the default
// registers. in_stall is high while a tick is in progress or its result waits
// for the output register.
`timescale 1ns / 1ps

module rocket_point_mass_euler_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [39:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] vertical_position,
	output logic signed [47:0] horizontal_position,
	output logic signed [31:0] vertical_velocity,
	output logic signed [31:0] horizontal_velocity,
	output logic [31:0]        total_speed,
	output logic [39:0]        remaining_fuel,
	output logic               engine_burning,
	output logic               saturated,
	output logic               mass_fault
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_G, ST_RATE, ST_DY, ST_DX, ST_THR, ST_BURN, ST_TY, ST_TX,
		ST_DIVY, ST_DIVX, ST_DVY, ST_DVX, ST_VY2, ST_VX2, ST_SQRT, ST_DPY,
		ST_DPX, ST_OUT
	} state_t;

	// Configuration registers.
	logic [39:0] dry_q, init_fuel_q, flow_q;
	logic [31:0] ve_q, drag_q;
	logic [17:0] cos_q, sin_q;
	logic [23:0] dt_q;

	// Integrator state and per-tick temporaries.
	state_t      state_q;
	logic        issued_q;
	logic [39:0] fuel_q;
	logic [31:0] vv_q, hv_q, sp_q;
	logic [47:0] vp_q, hp_q;
	logic [40:0] mass_q;
	logic [63:0] fy_q, fx_q, ay_q, ax_q, vsum_q;
	logic [62:0] rate_q, thr_q, burned_q, vy2_q;
	logic        sat_q, burn_q, fault_q;

	// Output register.
	logic        out_valid_q;
	logic [47:0] o_vp_q, o_hp_q;
	logic [31:0] o_vv_q, o_hv_q, o_sp_q;
	logic [39:0] o_fuel_q;
	logic        o_burn_q, o_sat_q, o_fault_q;

	// Arithmetic unit connections.
	logic            mul_start, div_start, sqrt_start;
	logic [63:0]     mul_a, mul_b, div_n, sqrt_x;
	rpm_pkg::shift_t mul_sh;
	logic            mul_done, div_done, sqrt_done;
	logic [62:0]     mul_res, div_q;
	logic            mul_sat, div_sat;
	logic [31:0]     sqrt_r;

	logic        accept, can_load, busy_op, unit_done;
	logic [40:0] mass_now;
	logic [31:0] vv_mag, hv_mag;
	logic [17:0] cos_mag, sin_mag;
	logic [63:0] fy_mag, fx_mag, ay_mag, ax_mag;

	// Apply a sign to a capped magnitude.
	function automatic logic [63:0] sgn(input logic neg, input logic [62:0] m);
		logic [63:0] e;
		e = {1'b0, m};
		return neg ? (~e + 64'd1) : e;
	endfunction

	// True when a signed value does not fit in the given number of bits.
	function automatic logic ovf(input logic [63:0] x, input int bits);
		logic [63:0] t;
		t = 64'($signed(x) >>> (bits - 1));
		return (t != '0) && (t != '1);
	endfunction

	// Saturate a signed value to the given number of bits.
	function automatic logic [63:0] clip(input logic [63:0] x, input int bits);
		logic [63:0] mx;
		mx = (64'd1 << (bits - 1)) - 64'd1;
		if (!ovf(x, bits)) begin
			return x;
		end
		return x[63] ? ~mx : mx;
	endfunction

	// Signed division by four, truncating toward zero.
	function automatic logic [63:0] tdiv4(input logic [63:0] x);
		logic [63:0] t;
		t = x + (x[63] ? 64'd3 : 64'd0);
		return 64'($signed(t) >>> 2);
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	always_comb begin
		accept    = in_valid && !in_stall;
		can_load  = !out_valid_q || !out_stall;
		busy_op   = (state_q != ST_IDLE) && (state_q != ST_OUT);
		unit_done = mul_done | div_done | sqrt_done;
		mass_now  = {1'b0, dry_q} + {1'b0, fuel_q};
		vv_mag    = vv_q[31] ? (~vv_q + 32'd1) : vv_q;
		hv_mag    = hv_q[31] ? (~hv_q + 32'd1) : hv_q;
		cos_mag   = cos_q[17] ? (~cos_q + 18'd1) : cos_q;
		sin_mag   = sin_q[17] ? (~sin_q + 18'd1) : sin_q;
		fy_mag    = mag64(fy_q);
		fx_mag    = mag64(fx_q);
		ay_mag    = mag64(ay_q);
		ax_mag    = mag64(ax_q);
	end

	assign in_stall = (state_q != ST_IDLE);

	// Operand selection for the shared units; a start pulses once per step.
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		mul_sh     = rpm_pkg::SH_16;
		mul_start  = 1'b0;
		div_n      = '0;
		div_start  = 1'b0;
		sqrt_x     = vsum_q;
		sqrt_start = 1'b0;
		unique case (state_q)
			ST_G: begin
				mul_a = {23'd0, mass_q};
				mul_b = rpm_pkg::GRAVITY_MAG;
			end
			ST_RATE: begin
				mul_a  = {32'd0, drag_q};
				mul_b  = {32'd0, sp_q};
				mul_sh = rpm_pkg::SH_24;
			end
			ST_DY: begin
				mul_a = {32'd0, vv_mag};
				mul_b = {1'b0, rate_q};
			end
			ST_DX: begin
				mul_a = {32'd0, hv_mag};
				mul_b = {1'b0, rate_q};
			end
			ST_THR: begin
				mul_a = {24'd0, flow_q};
				mul_b = {32'd0, ve_q};
			end
			ST_BURN: begin
				mul_a  = {24'd0, flow_q};
				mul_b  = {40'd0, dt_q};
				mul_sh = rpm_pkg::SH_24;
			end
			ST_TY: begin
				mul_a = {46'd0, cos_mag};
				mul_b = {1'b0, thr_q};
			end
			ST_TX: begin
				mul_a = {46'd0, sin_mag};
				mul_b = {1'b0, thr_q};
			end
			ST_DIVY: div_n = fy_mag;
			ST_DIVX: div_n = fx_mag;
			ST_DVY: begin
				mul_a  = ay_mag;
				mul_b  = {40'd0, dt_q};
				mul_sh = rpm_pkg::SH_24;
			end
			ST_DVX: begin
				mul_a  = ax_mag;
				mul_b  = {40'd0, dt_q};
				mul_sh = rpm_pkg::SH_24;
			end
			ST_VY2: begin
				mul_a  = {32'd0, vv_mag};
				mul_b  = {32'd0, vv_mag};
				mul_sh = rpm_pkg::SH_0;
			end
			ST_VX2: begin
				mul_a  = {32'd0, hv_mag};
				mul_b  = {32'd0, hv_mag};
				mul_sh = rpm_pkg::SH_0;
			end
			ST_DPY: begin
				mul_a  = {32'd0, vv_mag};
				mul_b  = {40'd0, dt_q};
				mul_sh = rpm_pkg::SH_24;
			end
			ST_DPX: begin
				mul_a  = {32'd0, hv_mag};
				mul_b  = {40'd0, dt_q};
				mul_sh = rpm_pkg::SH_24;
			end
			default: begin
			end
		endcase
		if (busy_op && !issued_q) begin
			if (state_q == ST_DIVY || state_q == ST_DIVX) begin
				div_start = 1'b1;
			end else if (state_q == ST_SQRT) begin
				sqrt_start = 1'b1;
			end else begin
				mul_start = 1'b1;
			end
		end
	end

	rpm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	rpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (mass_q),
		.done   (div_done),
		.q      (div_q),
		.sat    (div_sat)
	);

	rpm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (sqrt_x),
		.done   (sqrt_done),
		.r      (sqrt_r)
	);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q       <= 40'd65536;
			init_fuel_q <= '0;
			flow_q      <= '0;
			ve_q        <= '0;
			drag_q      <= '0;
			cos_q       <= 18'd65536;
			sin_q       <= '0;
			dt_q        <= 24'd167772;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rpm_pkg::REG_DRY_MASS:    dry_q       <= cfg_data;
				rpm_pkg::REG_INIT_FUEL:   init_fuel_q <= cfg_data;
				rpm_pkg::REG_FLOW:        flow_q      <= cfg_data;
				rpm_pkg::REG_EXHAUST_VEL: ve_q        <= cfg_data[31:0];
				rpm_pkg::REG_DRAG:        drag_q      <= cfg_data[31:0];
				rpm_pkg::REG_COS_PITCH:   cos_q       <= cfg_data[17:0];
				rpm_pkg::REG_SIN_PITCH:   sin_q       <= cfg_data[17:0];
				rpm_pkg::REG_TIME_STEP:   dt_q        <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// Tick sequencer, integrator state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [63:0] sv;
		logic [63:0] sum;
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			fuel_q      <= '0;
			vv_q        <= '0;
			hv_q        <= '0;
			sp_q        <= '0;
			vp_q        <= '0;
			hp_q        <= '0;
			mass_q      <= '0;
			fy_q        <= '0;
			fx_q        <= '0;
			ay_q        <= '0;
			ax_q        <= '0;
			vsum_q      <= '0;
			rate_q      <= '0;
			thr_q       <= '0;
			burned_q    <= '0;
			vy2_q       <= '0;
			sat_q       <= 1'b0;
			burn_q      <= 1'b0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
			o_vp_q      <= '0;
			o_hp_q      <= '0;
			o_vv_q      <= '0;
			o_hv_q      <= '0;
			o_sp_q      <= '0;
			o_fuel_q    <= '0;
			o_burn_q    <= 1'b0;
			o_sat_q     <= 1'b0;
			o_fault_q   <= 1'b0;
		end else begin
			// The output register empties on a transfer unless a new result replaces it.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_IDLE) begin
				if (accept) begin
					sat_q   <= 1'b0;
					burn_q  <= 1'b0;
					mass_q  <= mass_now;
					if (restart) begin
						fault_q <= 1'b0;
						fuel_q  <= init_fuel_q;
						vv_q    <= '0;
						hv_q    <= '0;
						sp_q    <= '0;
						vp_q    <= '0;
						hp_q    <= '0;
						state_q <= ST_OUT;
					end else if (mass_now == 41'd0) begin
						fault_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						fault_q <= 1'b0;
						state_q <= ST_G;
					end
				end
			end else if (state_q == ST_OUT) begin
				if (can_load) begin
					out_valid_q <= 1'b1;
					o_vp_q      <= vp_q;
					o_hp_q      <= hp_q;
					o_vv_q      <= vv_q;
					o_hv_q      <= hv_q;
					o_sp_q      <= sp_q;
					o_fuel_q    <= fuel_q;
					o_burn_q    <= burn_q;
					o_sat_q     <= sat_q;
					o_fault_q   <= fault_q;
					state_q     <= ST_IDLE;
				end
			end else if (!issued_q) begin
				issued_q <= 1'b1;
			end else if (unit_done) begin
				issued_q <= 1'b0;
				unique case (state_q)
					ST_G: begin
						fy_q    <= sgn(1'b1, mul_res);
						sat_q   <= sat_q | mul_sat;
						state_q <= ST_RATE;
					end
					ST_RATE: begin
						rate_q  <= mul_res;
						sat_q   <= sat_q | mul_sat;
						state_q <= ST_DY;
					end
					ST_DY: begin
						fy_q    <= fy_q - sgn(vv_q[31], mul_res);
						sat_q   <= sat_q | mul_sat;
						state_q <= ST_DX;
					end
					ST_DX: begin
						fx_q    <= 64'd0 - sgn(hv_q[31], mul_res);
						sat_q   <= sat_q | mul_sat;
						state_q <= (fuel_q != 40'd0) ? ST_THR : ST_DIVY;
					end
					ST_THR: begin
						thr_q   <= mul_res;
						sat_q   <= sat_q | mul_sat;
						state_q <= ST_BURN;
					end
					ST_BURN: begin
						burned_q <= mul_res;
						sat_q    <= sat_q | mul_sat;
						state_q  <= ST_TY;
					end
					ST_TY: begin
						sum     = tdiv4(fy_q) + tdiv4(sgn(cos_q[17], mul_res));
						sv      = clip(sum, 61);
						fy_q    <= {sv[61:0], 2'b00};
						sat_q   <= sat_q | mul_sat | ovf(sum, 61);
						state_q <= ST_TX;
					end
					ST_TX: begin
						sum     = tdiv4(fx_q) + tdiv4(sgn(sin_q[17], mul_res));
						sv      = clip(sum, 61);
						fx_q    <= {sv[61:0], 2'b00};
						sat_q   <= sat_q | mul_sat | ovf(sum, 61);
						burn_q  <= 1'b1;
						// Fuel burned this tick, clamped at empty.
						if (burned_q >= {23'd0, fuel_q}) begin
							fuel_q <= '0;
						end else begin
							fuel_q <= fuel_q - burned_q[39:0];
						end
						state_q <= ST_DIVY;
					end
					ST_DIVY: begin
						ay_q    <= sgn(fy_q[63], div_q);
						sat_q   <= sat_q | div_sat;
						state_q <= ST_DIVX;
					end
					ST_DIVX: begin
						ax_q    <= sgn(fx_q[63], div_q);
						sat_q   <= sat_q | div_sat;
						state_q <= ST_DVY;
					end
					ST_DVY: begin
						sum     = {{32{vv_q[31]}}, vv_q} + sgn(ay_q[63], mul_res);
						sv      = clip(sum, 32);
						vv_q    <= sv[31:0];
						sat_q   <= sat_q | mul_sat | ovf(sum, 32);
						state_q <= ST_DVX;
					end
					ST_DVX: begin
						sum     = {{32{hv_q[31]}}, hv_q} + sgn(ax_q[63], mul_res);
						sv      = clip(sum, 32);
						hv_q    <= sv[31:0];
						sat_q   <= sat_q | mul_sat | ovf(sum, 32);
						state_q <= ST_VY2;
					end
					ST_VY2: begin
						vy2_q   <= mul_res;
						state_q <= ST_VX2;
					end
					ST_VX2: begin
						vsum_q  <= {1'b0, vy2_q} + {1'b0, mul_res};
						state_q <= ST_SQRT;
					end
					ST_SQRT: begin
						sp_q    <= sqrt_r;
						state_q <= ST_DPY;
					end
					ST_DPY: begin
						sum     = {{16{vp_q[47]}}, vp_q} + sgn(vv_q[31], mul_res);
						sv      = clip(sum, 48);
						vp_q    <= sv[47:0];
						sat_q   <= sat_q | mul_sat | ovf(sum, 48);
						state_q <= ST_DPX;
					end
					ST_DPX: begin
						sum     = {{16{hp_q[47]}}, hp_q} + sgn(hv_q[31], mul_res);
						sv      = clip(sum, 48);
						hp_q    <= sv[47:0];
						sat_q   <= sat_q | mul_sat | ovf(sum, 48);
						state_q <= ST_OUT;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign vertical_position   = o_vp_q;
	assign horizontal_position = o_hp_q;
	assign vertical_velocity   = o_vv_q;
	assign horizontal_velocity = o_hv_q;
	assign total_speed         = o_sp_q;
	assign remaining_fuel      = o_fuel_q;
	assign engine_burning      = o_burn_q;
	assign saturated           = o_sat_q;
	assign mass_fault          = o_fault_q;

endmodule

// ===== dv/tb_rocket_point_mass_euler_step.sv =====
// Self-checking testbench for the point-mass rocket integrator.
// Depends on rpm_pkg and rocket_point_mass_euler_step; runs directed rows, then random phases.
`timescale 1ns / 1ps

module tb_rocket_point_mass_euler_step;

	// One tick result as the block reports it.
	typedef struct packed {
		logic signed [47:0] pos_v;
		logic signed [47:0] pos_h;
		logic signed [31:0] vel_v;
		logic signed [31:0] vel_h;
		logic [31:0]        speed;
		logic [39:0]        fuel;
		logic               burn;
		logic               sat;
		logic               fault;
	} flight_state_t;

	typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

	// One line of the directed stimulus table.
	typedef struct {
		row_kind_t     kind;
		logic [2:0]    idx;
		logic [39:0]   data;
		logic          rst;
		logic          typed;
		flight_state_t want;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam logic [127:0] CAP = 128'd1 << 62;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = rpm_pkg::REG_DRY_MASS;
	logic [39:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [47:0] vertical_position;
	logic signed [47:0] horizontal_position;
	logic signed [31:0] vertical_velocity;
	logic signed [31:0] horizontal_velocity;
	logic [31:0]        total_speed;
	logic [39:0]        remaining_fuel;
	logic               engine_burning;
	logic               saturated;
	logic               mass_fault;

	rocket_point_mass_euler_step dut (.*);

	// Shadow configuration and flight state.
	logic [63:0]        m_dry, m_init_fuel, m_flow, m_exhaust, m_drag, m_dt;
	logic signed [63:0] m_cos, m_sin;
	logic [63:0]        s_fuel, s_speed;
	logic signed [63:0] s_vel_v, s_vel_h, s_pos_v, s_pos_h;
	logic               tick_sat;

	flight_state_t expected_states[$];
	dir_row_t      dir_rows[$];
	logic          use_typed = 1'b0;
	flight_state_t typed_state;
	int            sent_ticks = 0;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	int            send_pct = 0;
	int            stall_pct = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Unsigned product shifted right, capped at 2^62.
	function automatic logic [63:0] prod_cap(logic [63:0] a, logic [63:0] b, int unsigned sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		if (p > CAP) begin
			tick_sat = 1'b1;
			return CAP[63:0];
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] magn(logic signed [63:0] a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	// Signed times unsigned, truncated toward zero.
	function automatic logic signed [63:0] sprod_cap(logic signed [63:0] a, logic [63:0] b,
			int unsigned sh);
		logic [63:0] m;
		m = prod_cap(magn(a), b, sh);
		return a < 0 ? -$signed(m) : $signed(m);
	endfunction

	// Force over mass in Q.16, truncated toward zero and capped.
	function automatic logic signed [63:0] force_to_accel(logic signed [63:0] f, logic [63:0] m);
		logic [127:0] q;
		q = ({64'd0, magn(f)} << 16) / {64'd0, m};
		if (q > CAP) begin
			tick_sat = 1'b1;
			q = CAP;
		end
		return f < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [63:0] clamp_bits(logic signed [63:0] v, int bits);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) begin
			tick_sat = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			tick_sat = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [127:0] r;
		logic [127:0] t;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= {64'd0, x})
				r = t;
		end
		return r[63:0];
	endfunction

	// Advances the shadow flight state by one item and returns the result it shows.
	function automatic flight_state_t integrate_tick(logic rst);
		flight_state_t      r;
		logic [63:0]        mass, rate, thr, burned;
		logic signed [63:0] fy, fx, ay, ax;
		logic               burn, fault;
		tick_sat = 1'b0;
		burn = 1'b0;
		fault = 1'b0;
		mass = m_dry + s_fuel;
		if (rst) begin
			s_fuel = m_init_fuel;
			s_vel_v = 0;
			s_vel_h = 0;
			s_speed = 0;
			s_pos_v = 0;
			s_pos_h = 0;
		end else if (mass == 0) begin
			fault = 1'b1;
		end else begin
			fy = -$signed(prod_cap(mass, rpm_pkg::GRAVITY_MAG, 16));
			rate = prod_cap(m_drag, s_speed, 24);
			fy = fy - sprod_cap(s_vel_v, rate, 16);
			fx = -sprod_cap(s_vel_h, rate, 16);
			if (s_fuel > 0) begin
				thr = prod_cap(m_flow, m_exhaust, 16);
				burned = prod_cap(m_flow, m_dt, 24);
				burn = 1'b1;
				fy = clamp_bits(fy / 4 + sprod_cap(m_cos, thr, 16) / 4, 61) * 4;
				fx = clamp_bits(fx / 4 + sprod_cap(m_sin, thr, 16) / 4, 61) * 4;
				s_fuel = burned >= s_fuel ? 64'd0 : s_fuel - burned;
			end
			ay = force_to_accel(fy, mass);
			ax = force_to_accel(fx, mass);
			s_vel_v = clamp_bits(s_vel_v + sprod_cap(ay, m_dt, 24), 32);
			s_vel_h = clamp_bits(s_vel_h + sprod_cap(ax, m_dt, 24), 32);
			s_speed = root_floor(magn(s_vel_v) * magn(s_vel_v) + magn(s_vel_h) * magn(s_vel_h));
			s_pos_v = clamp_bits(s_pos_v + sprod_cap(s_vel_v, m_dt, 24), 48);
			s_pos_h = clamp_bits(s_pos_h + sprod_cap(s_vel_h, m_dt, 24), 48);
		end
		r.pos_v = s_pos_v[47:0];
		r.pos_h = s_pos_h[47:0];
		r.vel_v = s_vel_v[31:0];
		r.vel_h = s_vel_h[31:0];
		r.speed = s_speed[31:0];
		r.fuel = s_fuel[39:0];
		r.burn = burn;
		r.sat = tick_sat && !rst;
		r.fault = fault;
		return r;
	endfunction

	// Result expected after a restart, or after a fault from the cleared state.
	function automatic flight_state_t cleared_state(logic [39:0] fuel, logic fault);
		flight_state_t r;
		r = '{default: '0};
		r.fuel = fuel;
		r.fault = fault;
		return r;
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [39:0] data);
		dir_rows.push_back('{ROW_CFG, idx, data, 1'b0, 1'b0, cleared_state('0, 1'b0)});
	endfunction

	function automatic void add_tick(logic rst, logic typed, flight_state_t want);
		dir_rows.push_back('{ROW_ITEM, rpm_pkg::REG_DRY_MASS, '0, rst, typed, want});
	endfunction

	// Random register value: mostly a plausible range, sometimes an extreme.
	function automatic logic [39:0] pick_reg(int w, int unsigned lo, int unsigned hi);
		logic [39:0] mask;
		mask = (40'd1 << w) - 40'd1;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return mask;
			2: return 40'({$urandom, $urandom}) & mask;
			default: return 40'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [39:0] pick_pitch();
		if ($urandom_range(0, 5) == 0)
			return 40'($urandom_range(0, 18'h3FFFF));
		return 40'(18'($urandom_range(0, 131072) - 65536));
	endfunction

	// Shadow registers follow every write.
	task automatic write_reg(logic [2:0] idx, logic [39:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			rpm_pkg::REG_DRY_MASS:    m_dry = {24'd0, data};
			rpm_pkg::REG_INIT_FUEL:   m_init_fuel = {24'd0, data};
			rpm_pkg::REG_FLOW:        m_flow = {24'd0, data};
			rpm_pkg::REG_EXHAUST_VEL: m_exhaust = {32'd0, data[31:0]};
			rpm_pkg::REG_DRAG:        m_drag = {32'd0, data[31:0]};
			rpm_pkg::REG_COS_PITCH:   m_cos = $signed(data[17:0]);
			rpm_pkg::REG_SIN_PITCH:   m_sin = $signed(data[17:0]);
			rpm_pkg::REG_TIME_STEP:   m_dt = {40'd0, data[23:0]};
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Waits for every outstanding result, then a short settle time.
	task automatic drain();
		while (expected_states.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Presents one item and holds it until the transfer completes.
	task automatic send_tick(logic rst, logic typed, flight_state_t want);
		int target;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		target = sent_ticks + 1;
		use_typed = typed;
		typed_state = want;
		restart = rst;
		in_valid = 1'b1;
		do
			@(negedge clk);
		while (sent_ticks != target);
		in_valid = 1'b0;
		restart = 1'($urandom_range(0, 1));
	endtask

	// Receiver stall pattern.
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// Result checking, prediction on accepted items, and the watchdog.
	always @(posedge clk) begin
		flight_state_t got, want;
		if (out_valid && !out_stall) begin
			got = '{vertical_position, horizontal_position, vertical_velocity,
				horizontal_velocity, total_speed, remaining_fuel, engine_burning,
				saturated, mass_fault};
			if (expected_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at %0t", $realtime);
			end else begin
				want = expected_states.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at %0t: exp pos %h %h vel %h %h spd %h fuel %h",
							" b/s/f %b%b%b; got pos %h %h vel %h %h spd %h fuel %h b/s/f %b%b%b"},
							$realtime, want.pos_v, want.pos_h, want.vel_v, want.vel_h,
							want.speed, want.fuel, want.burn, want.sat, want.fault,
							got.pos_v, got.pos_h, got.vel_v, got.vel_h, got.speed, got.fuel,
							got.burn, got.sat, got.fault);
				end
			end
		end
		if (in_valid && !in_stall) begin
			want = integrate_tick(restart);
			expected_states.push_back(use_typed ? typed_state : want);
			sent_ticks++;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_rocket_point_mass_euler_step: done, errors");
			$finish;
		end
	end

	initial begin
		flight_state_t none;
		none = cleared_state('0, 1'b0);
		m_dry = 65536;
		m_init_fuel = 0;
		m_flow = 0;
		m_exhaust = 0;
		m_drag = 0;
		m_cos = 65536;
		m_sin = 0;
		m_dt = 167772;
		s_fuel = 0;
		s_speed = 0;
		s_vel_v = 0;
		s_vel_h = 0;
		s_pos_v = 0;
		s_pos_h = 0;

		// Directed table: defaults, zero mass, extremes, odd pitch, zero time step, fuel clamp.
		add_tick(1'b1, 1'b1, cleared_state('0, 1'b0));
		add_tick(1'b0, 1'b0, none);
		add_tick(1'b0, 1'b0, none);
		add_cfg(rpm_pkg::REG_DRY_MASS, '0);
		add_tick(1'b1, 1'b1, cleared_state('0, 1'b0));
		add_tick(1'b0, 1'b1, cleared_state('0, 1'b1));
		add_cfg(rpm_pkg::REG_DRY_MASS, 40'hFF_FFFF_FFFF);
		add_cfg(rpm_pkg::REG_INIT_FUEL, 40'hFF_FFFF_FFFF);
		add_cfg(rpm_pkg::REG_FLOW, 40'hFF_FFFF_FFFF);
		add_cfg(rpm_pkg::REG_EXHAUST_VEL, 40'hFFFF_FFFF);
		add_cfg(rpm_pkg::REG_DRAG, 40'hFFFF_FFFF);
		add_cfg(rpm_pkg::REG_COS_PITCH, 40'h3_0000);
		add_cfg(rpm_pkg::REG_SIN_PITCH, 40'h1_0000);
		add_cfg(rpm_pkg::REG_TIME_STEP, 40'hFF_FFFF);
		add_tick(1'b1, 1'b1, cleared_state(40'hFF_FFFF_FFFF, 1'b0));
		add_tick(1'b0, 1'b0, none);
		add_tick(1'b0, 1'b0, none);
		add_cfg(rpm_pkg::REG_COS_PITCH, 40'h2_0000);
		add_cfg(rpm_pkg::REG_SIN_PITCH, 40'h1_FFFF);
		add_tick(1'b0, 1'b0, none);
		add_cfg(rpm_pkg::REG_TIME_STEP, '0);
		add_tick(1'b0, 1'b0, none);
		add_cfg(rpm_pkg::REG_DRY_MASS, 40'h1_0000);
		add_cfg(rpm_pkg::REG_INIT_FUEL, 40'd100);
		add_cfg(rpm_pkg::REG_FLOW, 40'h4000_0000);
		add_cfg(rpm_pkg::REG_EXHAUST_VEL, 40'h0BB8_0000);
		add_cfg(rpm_pkg::REG_DRAG, 40'h0010_0000);
		add_cfg(rpm_pkg::REG_COS_PITCH, 40'h0_F000);
		add_cfg(rpm_pkg::REG_SIN_PITCH, 40'h3_A000);
		add_cfg(rpm_pkg::REG_TIME_STEP, 40'h02_8F5C);
		add_tick(1'b1, 1'b1, cleared_state(40'd100, 1'b0));
		add_tick(1'b0, 1'b0, none);
		add_tick(1'b0, 1'b0, none);
		add_tick(1'b0, 1'b0, none);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_tick(dir_rows[i].rst, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases: fresh settings, then a flight with occasional restarts.
		for (int phase = 0; phase < 32; phase++) begin
			drain();
			write_reg(rpm_pkg::REG_DRY_MASS, pick_reg(40, 1 << 16, 1 << 26));
			write_reg(rpm_pkg::REG_INIT_FUEL, pick_reg(40, 0, 1 << 26));
			write_reg(rpm_pkg::REG_FLOW, pick_reg(40, 0, 1 << 22));
			write_reg(rpm_pkg::REG_EXHAUST_VEL, pick_reg(32, 0, 32'd196608000));
			write_reg(rpm_pkg::REG_DRAG, pick_reg(32, 0, 1 << 24));
			write_reg(rpm_pkg::REG_COS_PITCH, pick_pitch());
			write_reg(rpm_pkg::REG_SIN_PITCH, pick_pitch());
			write_reg(rpm_pkg::REG_TIME_STEP, pick_reg(24, 1000, 400000));
			case (phase % 4)
				0: begin send_pct = 0; stall_pct = 0; end
				1: begin send_pct = 52; stall_pct = 0; end
				2: begin send_pct = 0; stall_pct = 52; end
				default: begin send_pct = 36; stall_pct = 36; end
			endcase
			send_tick(1'b1, 1'b0, none);
			for (int k = 1; k < 60; k++)
				send_tick($urandom_range(0, 15) == 0, 1'b0, none);
		end

		send_pct = 0;
		drain();
		stall_pct = 0;
		repeat (1200) @(negedge clk);
		if (mismatches == 0 && expected_states.size() == 0)
			$display("tb_rocket_point_mass_euler_step: done, clean");
		else
			$display("tb_rocket_point_mass_euler_step: done, errors");
		$finish;
	end

endmodule

// ===== rocket_point_mass_euler_step.f =====
hdl/rpm_pkg.sv
hdl/rpm_mul.sv
hdl/rpm_div.sv
hdl/rpm_sqrt.sv
hdl/rocket_point_mass_euler_step.sv
dv/tb_rocket_point_mass_euler_step.sv
